FILE: src/ecal_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helper functions for the epoch to calendar converter
package ecal_pkg;

  // default width of the seconds count
  localparam int SECONDS_BITS_DEF = 36;

  // time unit constants
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // day counts of the march-based gregorian cycle
  localparam int DAYS_PER_ERA  = 146097;
  localparam int DAYS_PER_CENT = 36524;
  localparam int DAYS_PER_QUAD = 1461;
  localparam int DAYS_PER_YEAR = 365;

  // days from 1600-03-01 to 1970-01-01
  localparam int EPOCH_SHIFT = 135080;
  // weekday of 1600-03-01 offset so that day zero of the era lands on wednesday
  localparam logic [17:0] WDAY_SHIFT = 18'd3;

  // quotient bits of the short divisions
  localparam int HOUR_STEPS = 5;
  localparam int MIN_STEPS  = 6;
  localparam int CEN_STEPS  = 2;
  localparam int QUAD_STEPS = 5;
  localparam int YEAR_STEPS = 2;

  // march-based month numbers
  localparam logic [3:0] MARCH_JAN  = 4'd10;
  localparam logic [3:0] MARCH_LAST = 4'd11;

  // offsets between march-based and january-based counts
  localparam logic [8:0] DOY_MAR_FIRST = 9'd59;
  localparam logic [8:0] DOY_JAN_FIRST = 9'd306;
  localparam logic [11:0] YEAR_BASE_OFS = 12'd300;

  // output beat layout
  localparam int OUT_FIELDS_W = 50;
  localparam int OUT_DATA_W   = 56;

  // control of the shared compare-subtract unit
  typedef struct packed {
    logic load;
    logic step;
    logic ext;
  } ecal_ctl_t;

  // one broken-down calendar result
  typedef struct packed {
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [11:0] year_since_1900;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ecal_result_t;

  // month lengths counted from march, february last
  function automatic logic [4:0] march_len(input logic [3:0] mi);
    logic [4:0] len;
    case (mi)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd30;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd31;
      default: len = 5'd29;
    endcase
    return len;
  endfunction

  // remainder by seven through octal digit sums, since eight is one mod seven
  function automatic logic [2:0] mod7_18(input logic [17:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = '0;
    for (int i = 0; i < 6; i++) begin
      s1 = s1 + 6'(v[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

FILE: src/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// top level of the epoch seconds to utc calendar converter
//
// A beat on the slave channel carries seconds since 1970-01-01 00:00:00 utc;
// bits of s_axis_tdata at or above SECONDS_BITS are ignored. Each input beat
// yields one beat on the master channel with second, minute, hour, day of
// month, month (0 is january), years since 1900, day of year and weekday
// (0 is sunday).
// One conversion at a time runs on a single compare-subtract unit: a restoring
// division by 86400, the hour and minute splits, the 400-year era split, the
// century, four-year and year splits, then a walk over up to eleven months.
// s_axis_tready is high only while the sequencer is idle, from the cycle after
// the result is registered, so a new beat is taken only once the previous
// conversion is through and its result has moved to the output register.
// The result sits in an output register; a stalled receiver holds the next
// finished result in the sequencer, and no new beat is taken until it moves.
// Synchronous reset returns the sequencer to idle and drops m_axis_tvalid.
module epoch_seconds_to_calendar #(
  parameter int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // epoch_seconds, zero padded to whole bytes
  input  logic [((SECONDS_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // second, minute, hour, day_of_month, month_index, year_since_1900,
  // day_of_year, weekday, zero padding
  output logic [ecal_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  logic                   start;
  logic                   busy;
  logic                   done;
  logic                   out_free;
  ecal_pkg::ecal_result_t result;

  // handshake on both sides
  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  ecal_seq #(
    .SECONDS_BITS (SECONDS_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .seconds_in (s_axis_tdata[SECONDS_BITS-1:0]),
    .out_free   (out_free),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output beat data, first field in the low bits
  always_ff @(posedge clk) begin
    if (done && out_free) begin
      m_axis_tdata <= ecal_pkg::OUT_DATA_W'({result.weekday, result.day_of_year,
                                             result.year_since_1900, result.month_index,
                                             result.day_of_month, result.hour,
                                             result.minute, result.second});
    end
  end

endmodule

FILE: src/ecal_sub_unit.sv
`timescale 1ns / 1ps
// shared compare-subtract unit, right-shift divisor, one quotient bit a cycle on step
module ecal_sub_unit #(
  parameter int W  = ecal_pkg::SECONDS_BITS_DEF + 1,
  parameter int QW = ecal_pkg::SECONDS_BITS_DEF - 16
) (
  input  logic                clk,
  input  ecal_pkg::ecal_ctl_t ctl,
  input  logic [W-1:0]        rem_in,
  input  logic [W-1:0]        dv_in,
  output logic [W-1:0]        rem,
  output logic [QW-1:0]       quo,
  output logic                ge
);

  logic [W-1:0] dv;
  logic [W-1:0] operand;

  // divisor comes from the register or straight from the sequencer
  assign operand = ctl.ext ? dv_in : dv;
  assign ge      = (rem >= operand);

  // load, or one restoring step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= rem_in;
      dv  <= dv_in;
      quo <= '0;
    end else if (ctl.step) begin
      if (ge) begin
        rem <= rem - operand;
      end
      quo <= {quo[QW-2:0], ge};
      if (!ctl.ext) begin
        dv <= dv >> 1;
      end
    end
  end

endmodule

FILE: src/ecal_seq.sv
`timescale 1ns / 1ps
// sequencer that runs the divisions and month walk on the shared unit
module ecal_seq #(
  parameter int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SECONDS_BITS-1:0] seconds_in,
  input  logic                   out_free,
  output logic                   busy,
  output logic                   done,
  output ecal_pkg::ecal_result_t result
);

  localparam int W     = SECONDS_BITS + 1;
  localparam int QD    = SECONDS_BITS - 16;
  localparam int ERA_W = SECONDS_BITS - 30;
  localparam int CNT_W = $clog2(QD + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DAY  = 4'd1;
  localparam logic [3:0] ST_HOUR = 4'd2;
  localparam logic [3:0] ST_MIN  = 4'd3;
  localparam logic [3:0] ST_ERA  = 4'd4;
  localparam logic [3:0] ST_CEN  = 4'd5;
  localparam logic [3:0] ST_QUAD = 4'd6;
  localparam logic [3:0] ST_YEAR = 4'd7;
  localparam logic [3:0] ST_MON  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]       state;
  logic [CNT_W-1:0] cnt;
  logic             in_div;

  ecal_pkg::ecal_ctl_t ctl;
  logic [W-1:0]  rem_in;
  logic [W-1:0]  dv_in;
  logic [W-1:0]  rem;
  logic [QD-1:0] quo;
  logic          ge;

  logic [QD-1:0]    days_r;
  logic [4:0]       hour_r;
  logic [5:0]       minute_r;
  logic [5:0]       second_r;
  logic [ERA_W-1:0] era_r;
  logic [2:0]       wday_r;
  logic [1:0]       cen_r;
  logic [4:0]       q4_r;
  logic [1:0]       yb_r;
  logic [8:0]       doym_r;
  logic [3:0]       mi;

  logic       jan_feb;
  logic       leap_m;
  logic [11:0] year_calc;

  ecal_sub_unit #(
    .W  (W),
    .QW (QD)
  ) u_sub (
    .clk    (clk),
    .ctl    (ctl),
    .rem_in (rem_in),
    .dv_in  (dv_in),
    .rem    (rem),
    .quo    (quo),
    .ge     (ge)
  );

  assign in_div = (state == ST_DAY) || (state == ST_HOUR) || (state == ST_MIN) ||
                  (state == ST_ERA) || (state == ST_CEN) || (state == ST_QUAD) ||
                  (state == ST_YEAR);
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);

  // commands to the shared unit
  always_comb begin
    ctl    = '0;
    rem_in = '0;
    dv_in  = '0;
    if (in_div && cnt != '0) begin
      ctl.step = 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            ctl.load = 1'b1;
            rem_in   = W'(seconds_in);
            dv_in    = W'(ecal_pkg::SECS_PER_DAY) << (QD - 1);
          end
        end
        ST_DAY: begin
          ctl.load = 1'b1;
          rem_in   = rem;
          dv_in    = W'(ecal_pkg::SECS_PER_HOUR) << (ecal_pkg::HOUR_STEPS - 1);
        end
        ST_HOUR: begin
          ctl.load = 1'b1;
          rem_in   = rem;
          dv_in    = W'(ecal_pkg::SECS_PER_MIN) << (ecal_pkg::MIN_STEPS - 1);
        end
        ST_MIN: begin
          ctl.load = 1'b1;
          rem_in   = W'(days_r) + W'(ecal_pkg::EPOCH_SHIFT);
          dv_in    = W'(ecal_pkg::DAYS_PER_ERA) << (ERA_W - 1);
        end
        ST_ERA: begin
          ctl.load = 1'b1;
          rem_in   = rem;
          dv_in    = W'(ecal_pkg::DAYS_PER_CENT) << (ecal_pkg::CEN_STEPS - 1);
        end
        ST_CEN: begin
          ctl.load = 1'b1;
          rem_in   = rem;
          dv_in    = W'(ecal_pkg::DAYS_PER_QUAD) << (ecal_pkg::QUAD_STEPS - 1);
        end
        ST_QUAD: begin
          ctl.load = 1'b1;
          rem_in   = rem;
          dv_in    = W'(ecal_pkg::DAYS_PER_YEAR) << (ecal_pkg::YEAR_STEPS - 1);
        end
        ST_MON: begin
          ctl.ext = 1'b1;
          dv_in   = W'(ecal_pkg::march_len(mi));
          if (mi != ecal_pkg::MARCH_LAST && ge) begin
            ctl.step = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // phase sequencing and capture of partial results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else if (in_div && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            cnt   <= CNT_W'(QD);
            state <= ST_DAY;
          end
        end
        ST_DAY: begin
          days_r <= quo;
          cnt    <= CNT_W'(ecal_pkg::HOUR_STEPS);
          state  <= ST_HOUR;
        end
        ST_HOUR: begin
          hour_r <= quo[4:0];
          cnt    <= CNT_W'(ecal_pkg::MIN_STEPS);
          state  <= ST_MIN;
        end
        ST_MIN: begin
          minute_r <= quo[5:0];
          second_r <= rem[5:0];
          cnt      <= CNT_W'(ERA_W);
          state    <= ST_ERA;
        end
        ST_ERA: begin
          era_r  <= quo[ERA_W-1:0];
          wday_r <= ecal_pkg::mod7_18(rem[17:0] + ecal_pkg::WDAY_SHIFT);
          cnt    <= CNT_W'(ecal_pkg::CEN_STEPS);
          state  <= ST_CEN;
        end
        ST_CEN: begin
          cen_r <= quo[1:0];
          cnt   <= CNT_W'(ecal_pkg::QUAD_STEPS);
          state <= ST_QUAD;
        end
        ST_QUAD: begin
          q4_r  <= quo[4:0];
          cnt   <= CNT_W'(ecal_pkg::YEAR_STEPS);
          state <= ST_YEAR;
        end
        ST_YEAR: begin
          yb_r   <= quo[1:0];
          doym_r <= rem[8:0];
          mi     <= '0;
          state  <= ST_MON;
        end
        ST_MON: begin
          if (mi != ecal_pkg::MARCH_LAST && ge) begin
            mi <= mi + 4'd1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // january and february belong to the next calendar year
  assign jan_feb = (mi >= ecal_pkg::MARCH_JAN);
  // leap test of the march-based year, by its place in the cycle
  assign leap_m  = (yb_r == 2'd0) && (q4_r != 5'd0 || cen_r == 2'd0);

  // year since 1900, in whole eras, centuries, quads and years from 1600
  assign year_calc = 12'(12'(era_r) * 12'd400) + 12'(12'(cen_r) * 12'd100) +
                     12'({q4_r, 2'b00}) + 12'(yb_r) + 12'(jan_feb) -
                     ecal_pkg::YEAR_BASE_OFS;

  // final result assembly
  always_comb begin
    result.second          = second_r;
    result.minute          = minute_r;
    result.hour            = hour_r;
    result.day_of_month    = rem[4:0] + 5'd1;
    result.month_index     = jan_feb ? (mi - ecal_pkg::MARCH_JAN) : (mi + 4'd2);
    result.year_since_1900 = year_calc;
    result.day_of_year     = jan_feb ? (doym_r - ecal_pkg::DOY_JAN_FIRST)
                                     : (doym_r + ecal_pkg::DOY_MAR_FIRST + 9'(leap_m));
    result.weekday         = wday_r;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the epoch seconds to utc calendar converter
module testbench;

  localparam int SECONDS_BITS = 36;
  localparam int IN_W = ((SECONDS_BITS + 7) / 8) * 8;
  localparam longint unsigned SEC_MAX = (64'd1 << SECONDS_BITS) - 1;
  localparam longint unsigned LAST_DAY =
    (64'd1 << SECONDS_BITS) / ecal_pkg::SECS_PER_DAY - 1;
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int RANDOM_ITEMS = 1525;
  localparam int CALM_TAIL = 150;

  // conversion queue and field comparison
  class calendar_scoreboard;
    ecal_pkg::ecal_result_t pending_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit is_leap(longint unsigned yr);
      if (yr % 4 != 0) return 1'b0;
      if (yr % 100 != 0) return 1'b1;
      return yr % 400 == 0;
    endfunction

    // gregorian breakdown: whole eras first, then years, then months
    function ecal_pkg::ecal_result_t to_calendar(logic [IN_W-1:0] beat);
      longint unsigned secs, days, rem, yr, dlen;
      int unsigned mon;
      ecal_pkg::ecal_result_t r;
      secs = 64'(beat[SECONDS_BITS-1:0]);
      days = secs / ecal_pkg::SECS_PER_DAY;
      yr = 1970 + 400 * (days / ecal_pkg::DAYS_PER_ERA);
      rem = days % ecal_pkg::DAYS_PER_ERA;
      while (rem >= (is_leap(yr) ? 366 : 365)) begin
        rem -= is_leap(yr) ? 366 : 365;
        yr++;
      end
      r.day_of_year = 9'(rem);
      mon = 0;
      while (mon < 11) begin
        dlen = MONTH_DAYS[mon];
        if (mon == 1 && is_leap(yr)) dlen = 29;
        if (rem < dlen) break;
        rem -= dlen;
        mon++;
      end
      r.second = 6'(secs % 60);
      r.minute = 6'((secs / 60) % 60);
      r.hour = 5'((secs / 3600) % 24);
      r.day_of_month = 5'(rem + 1);
      r.month_index = 4'(mon);
      r.year_since_1900 = 12'(yr - 1900);
      r.weekday = 3'((days + 4) % 7);
      return r;
    endfunction

    function void note_seconds(logic [IN_W-1:0] beat);
      pending_dates.push_back(to_calendar(beat));
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(logic [ecal_pkg::OUT_DATA_W-1:0] beat);
      ecal_pkg::ecal_result_t want, got;
      if (pending_dates.size() == 0) begin
        $error("result beat with no conversion outstanding: %h", beat);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      got = beat[ecal_pkg::OUT_FIELDS_W-1:0];
      compare_field("second", want.second, got.second);
      compare_field("minute", want.minute, got.minute);
      compare_field("hour", want.hour, got.hour);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("month_index", want.month_index, got.month_index);
      compare_field("year_since_1900", want.year_since_1900, got.year_since_1900);
      compare_field("day_of_year", want.day_of_year, got.day_of_year);
      compare_field("weekday", want.weekday, got.weekday);
      compare_field("padding", 0, beat[ecal_pkg::OUT_DATA_W-1:ecal_pkg::OUT_FIELDS_W]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ecal_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  calendar_scoreboard sb;
  int idle_pct = 0;

  logic [IN_W-1:0] edge_dates[$] = '{
    40'd0, 40'd59, 40'd60, 40'd3599, 40'd3600, 40'd86399, 40'd86400,
    40'd68169600,      // leap day of 1972
    40'd94694399,      // last second of a leap year
    40'd946684799,     // last second of 1999
    40'd951782400,     // leap day of a year divisible by 400
    40'd951868800,
    40'd978307199,     // day 365 of 2000
    40'd4107542399,    // end of february in a century non-leap year
    40'd4107542400,
    40'd4294967295, 40'd4294967296,
    40'd12622780799,   // around the first full 400-year era
    40'd12622780800,
    40'h0F_FFFF_FFFF,  // largest count
    40'hFF_FFFF_FFFF,  // bits above the count width ignored
    40'hF0_0000_0000,
    40'hA5_0001_5180
  };

  always #10 clk = ~clk;

  epoch_seconds_to_calendar #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // beat monitors on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_seconds(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    end
  end

  // random idle bursts, or none
  function int idle_burst();
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) return $urandom_range(1, 12);
    return 0;
  endfunction

  // offer one beat and hold it until taken
  task send_seconds(logic [IN_W-1:0] secs);
    int gap;
    gap = idle_burst();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= secs;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the sender off until every conversion has come back
  task wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_dates.size() > 0) @(posedge clk);
  endtask

  // counts spread over day edges, small values, the top end and the full range
  function logic [IN_W-1:0] random_epoch();
    logic [63:0] raw;
    longint unsigned days, secs;
    logic [IN_W-1:0] v;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = raw[IN_W-1:0];
      1: begin
        days = $urandom_range(0, LAST_DAY);
        secs = days * ecal_pkg::SECS_PER_DAY;
        if ($urandom_range(0, 1)) secs += ecal_pkg::SECS_PER_DAY - 1 - $urandom_range(0, 3);
        else secs += $urandom_range(0, 3);
        v = IN_W'(secs);
      end
      2: v = IN_W'(raw[31:0] >> $urandom_range(0, 31));
      default: v = IN_W'(SEC_MAX - raw[19:0]);
    endcase
    v[IN_W-1:SECONDS_BITS] = raw[63 -: IN_W - SECONDS_BITS];
    return v;
  endfunction

  // receiver with random stalls
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // sequence: reset, edge dates, random counts, drain
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 20;
    foreach (edge_dates[i]) send_seconds(edge_dates[i]);
    wait_for_results();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (i >= RANDOM_ITEMS - CALM_TAIL) idle_pct = 0;
      if (i == RANDOM_ITEMS / 2) wait_for_results();
      send_seconds(random_epoch());
    end
    wait_for_results();
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_dates.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/ecal_pkg.sv
src/ecal_sub_unit.sv
src/ecal_seq.sv
src/epoch_seconds_to_calendar.sv
dv/testbench.sv
